FILE: rtl/rle_isd_pkg.sv
// Shared types and constants for the run-length image stream decoder.
package rle_isd_pkg;

  // Run store capacity and derived widths
  localparam int MAX_RUNS = 1024;
  localparam int RUN_AW   = $clog2(MAX_RUNS);
  localparam int RUN_CW   = $clog2(MAX_RUNS + 1);
  localparam int LEN_W    = 32;
  localparam int COLOR_W  = 24;

  // Header layout
  localparam logic [7:0] GRAY_FLAG  = 8'd192;
  localparam logic [3:0] SKIP_A_LEN = 4'd14;
  localparam logic [3:0] WORD16_LEN = 4'd2;
  localparam logic [3:0] SKIP_B_LEN = 4'd4;
  localparam logic [3:0] SKIP_C_LEN = 4'd3;
  localparam logic [3:0] SKIP_D_LEN = 4'd4;
  localparam logic [3:0] WORD32_LEN = 4'd4;
  localparam logic [3:0] RGB_LEN    = 4'd3;

  // Stream commands (in_tuser) and result kinds (out_tuser)
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_PULL    = 1'b1;
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Result tdata layout
  localparam int OUT_DATA_W    = 64;
  localparam int OUT_USED_W    = 59;
  localparam int OUT_PAD_W     = OUT_DATA_W - OUT_USED_W;
  localparam int PIX_VALID_BIT = 57;

  typedef enum logic [3:0] {
    PH_SKIP_A,
    PH_WIDTH,
    PH_HEIGHT,
    PH_SKIP_B,
    PH_FLAG,
    PH_SKIP_C,
    PH_STRING,
    PH_SKIP_D,
    PH_COUNT,
    PH_LENS,
    PH_COLORS,
    PH_EMIT
  } phase_t;

  typedef enum logic {
    EM_IDLE,
    EM_READ
  } em_state_t;

  // Parser status seen by the expander
  typedef struct packed {
    logic [15:0]       width;
    logic [15:0]       height;
    logic              gray;
    logic              overflow;
    logic              emit_phase;
    logic [RUN_CW-1:0] colors_loaded;
  } parse_info_t;

  // Header result event, one cycle wide
  typedef struct packed {
    logic valid;
    logic overflow;
  } hdr_evt_t;

  // Write port into the run stores
  typedef struct packed {
    logic               len_we;
    logic               color_we;
    logic [RUN_AW-1:0]  addr;
    logic [LEN_W-1:0]   len_data;
    logic [COLOR_W-1:0] color_data;
  } store_wr_t;

endpackage

FILE: rtl/rle_isd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rle_isd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rle_isd_parser.sv
// Header and run-data parser: walks the byte stream and fills the run stores.
module rle_isd_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      byte_go,
  input  logic [7:0]                data_byte,
  output rle_isd_pkg::parse_info_t  info,
  output rle_isd_pkg::hdr_evt_t     hdr,
  output rle_isd_pkg::store_wr_t    wr
);

  rle_isd_pkg::phase_t               phase_r, phase_nxt;
  logic [3:0]                        cnt_r, cnt_nxt;
  logic [31:0]                       acc_r, acc_nxt;
  logic [15:0]                       width_r, width_nxt;
  logic [15:0]                       height_r, height_nxt;
  logic                              gray_r, gray_nxt;
  logic [31:0]                       total_r, total_nxt;
  logic [31:0]                       item_r, item_nxt;
  logic [rle_isd_pkg::RUN_CW-1:0]    loaded_r, loaded_nxt;
  logic [31:0]                       acc_shift;
  logic [31:0]                       item_inc;
  logic                              item_fits;
  logic                              color_done;
  logic [rle_isd_pkg::COLOR_W-1:0]   color_word;

  assign acc_shift = {acc_r[23:0], data_byte};
  assign item_inc  = item_r + 32'd1;
  assign item_fits = item_r < 32'(rle_isd_pkg::MAX_RUNS);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rle_isd_pkg::PH_SKIP_A;
      cnt_r    <= '0;
      acc_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      gray_r   <= 1'b0;
      total_r  <= '0;
      item_r   <= '0;
      loaded_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      gray_r   <= gray_nxt;
      total_r  <= total_nxt;
      item_r   <= item_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  // Per-byte parse step
  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    gray_nxt      = gray_r;
    total_nxt     = total_r;
    item_nxt      = item_r;
    loaded_nxt    = loaded_r;
    hdr.valid     = 1'b0;
    hdr.overflow  = acc_shift > 32'(rle_isd_pkg::MAX_RUNS);
    wr.len_we     = 1'b0;
    wr.color_we   = 1'b0;
    wr.addr       = item_r[rle_isd_pkg::RUN_AW-1:0];
    wr.len_data   = acc_shift;
    color_done    = 1'b0;
    color_word    = gray_r ? {3{data_byte}} : acc_shift[rle_isd_pkg::COLOR_W-1:0];
    wr.color_data = color_word;

    if (byte_go) begin
      case (phase_r)
        rle_isd_pkg::PH_SKIP_A: begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == rle_isd_pkg::SKIP_A_LEN - 4'd1) begin
            cnt_nxt   = '0;
            phase_nxt = rle_isd_pkg::PH_WIDTH;
          end
        end
        rle_isd_pkg::PH_WIDTH: begin
          width_nxt = {width_r[7:0], data_byte};
          cnt_nxt   = cnt_r + 4'd1;
          if (cnt_r == rle_isd_pkg::WORD16_LEN - 4'd1) begin
            cnt_nxt   = '0;
            phase_nxt = rle_isd_pkg::PH_HEIGHT;
          end
        end
        rle_isd_pkg::PH_HEIGHT: begin
          height_nxt = {height_r[7:0], data_byte};
          cnt_nxt    = cnt_r + 4'd1;
          if (cnt_r == rle_isd_pkg::WORD16_LEN - 4'd1) begin
            cnt_nxt   = '0;
            phase_nxt = rle_isd_pkg::PH_SKIP_B;
          end
        end
        rle_isd_pkg::PH_SKIP_B: begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == rle_isd_pkg::SKIP_B_LEN - 4'd1) begin
            cnt_nxt   = '0;
            phase_nxt = rle_isd_pkg::PH_FLAG;
          end
        end
        rle_isd_pkg::PH_FLAG: begin
          gray_nxt  = data_byte == rle_isd_pkg::GRAY_FLAG;
          cnt_nxt   = '0;
          phase_nxt = rle_isd_pkg::PH_SKIP_C;
        end
        rle_isd_pkg::PH_SKIP_C: begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == rle_isd_pkg::SKIP_C_LEN - 4'd1) begin
            cnt_nxt   = '0;
            phase_nxt = rle_isd_pkg::PH_STRING;
          end
        end
        rle_isd_pkg::PH_STRING: begin
          // name string runs up to and including its zero terminator
          if (data_byte == 8'd0) begin
            cnt_nxt   = '0;
            phase_nxt = rle_isd_pkg::PH_SKIP_D;
          end
        end
        rle_isd_pkg::PH_SKIP_D: begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == rle_isd_pkg::SKIP_D_LEN - 4'd1) begin
            cnt_nxt   = '0;
            acc_nxt   = '0;
            phase_nxt = rle_isd_pkg::PH_COUNT;
          end
        end
        rle_isd_pkg::PH_COUNT: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == rle_isd_pkg::WORD32_LEN - 4'd1) begin
            total_nxt  = acc_shift;
            cnt_nxt    = '0;
            acc_nxt    = '0;
            item_nxt   = '0;
            loaded_nxt = '0;
            hdr.valid  = 1'b1;
            phase_nxt  = (acc_shift == 32'd0) ? rle_isd_pkg::PH_EMIT : rle_isd_pkg::PH_LENS;
          end
        end
        rle_isd_pkg::PH_LENS: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == rle_isd_pkg::WORD32_LEN - 4'd1) begin
            wr.len_we = item_fits;
            item_nxt  = item_inc;
            cnt_nxt   = '0;
            acc_nxt   = '0;
            if (item_inc == total_r) begin
              item_nxt  = '0;
              phase_nxt = rle_isd_pkg::PH_COLORS;
            end
          end
        end
        rle_isd_pkg::PH_COLORS: begin
          if (gray_r) begin
            color_done = 1'b1;
          end else begin
            acc_nxt = acc_shift;
            cnt_nxt = cnt_r + 4'd1;
            if (cnt_r == rle_isd_pkg::RGB_LEN - 4'd1) begin
              color_done = 1'b1;
            end
          end
          // one color complete: store it if the store has room, and advance
          if (color_done) begin
            wr.color_we = item_fits;
            if (item_fits) begin
              loaded_nxt = item_inc[rle_isd_pkg::RUN_CW-1:0];
            end
            item_nxt = item_inc;
            cnt_nxt  = '0;
            acc_nxt  = '0;
            if (item_inc == total_r) begin
              phase_nxt = rle_isd_pkg::PH_EMIT;
            end
          end
        end
        default: begin
          // expansion phase: further bytes are dropped
        end
      endcase
    end
  end

  // Status toward the expander
  assign info.width         = width_r;
  assign info.height        = height_r;
  assign info.gray          = gray_r;
  assign info.overflow      = total_r > 32'(rle_isd_pkg::MAX_RUNS);
  assign info.emit_phase    = phase_r == rle_isd_pkg::PH_EMIT;
  assign info.colors_loaded = loaded_r;

endmodule

FILE: rtl/rle_isd_expander.sv
// Run expander: turns pulls into pixel results and owns the result register.
module rle_isd_expander (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               pull_go,
  output logic                               busy,
  input  rle_isd_pkg::parse_info_t           info,
  input  rle_isd_pkg::hdr_evt_t              hdr,
  output logic [rle_isd_pkg::RUN_AW-1:0]     rd_addr,
  input  logic [rle_isd_pkg::LEN_W-1:0]      rd_len,
  input  logic [rle_isd_pkg::COLOR_W-1:0]    rd_color,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rle_isd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);

  rle_isd_pkg::em_state_t                   state_r, state_nxt;
  logic [rle_isd_pkg::RUN_CW-1:0]           run_r, run_nxt;
  logic [31:0]                              cnt_r, cnt_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  logic                                     out_kind_r, out_kind_nxt;
  logic                                     out_last_r, out_last_nxt;
  logic [rle_isd_pkg::OUT_DATA_W-1:0]       out_data_r, out_data_nxt;
  logic                                     pull_ok;
  logic                                     len_zero;
  logic [31:0]                              cnt_inc;
  logic [rle_isd_pkg::RUN_CW-1:0]           run_inc;
  logic [rle_isd_pkg::COLOR_W-1:0]          pix_color;

  assign pull_ok   = info.emit_phase && (run_r < info.colors_loaded);
  assign len_zero  = rd_len == '0;
  assign cnt_inc   = cnt_r + 32'd1;
  assign run_inc   = run_r + 1'b1;
  assign pix_color = len_zero ? '0 : rd_color;
  assign rd_addr   = run_r[rle_isd_pkg::RUN_AW-1:0];
  assign busy      = state_r == rle_isd_pkg::EM_READ;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rle_isd_pkg::EM_IDLE;
      run_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state and result build
  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rle_isd_pkg::EM_IDLE: begin
        // memory read of the current run starts now
        if (pull_go && pull_ok) begin
          state_nxt = rle_isd_pkg::EM_READ;
        end
        if (hdr.valid) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rle_isd_pkg::KIND_HEADER;
          out_last_nxt  = 1'b0;
          out_data_nxt  = {{rle_isd_pkg::OUT_PAD_W{1'b0}}, hdr.overflow, 1'b0, 24'd0,
                           info.gray, info.height, info.width};
        end
      end
      rle_isd_pkg::EM_READ: begin
        state_nxt     = rle_isd_pkg::EM_IDLE;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = rle_isd_pkg::KIND_PIXEL;
        out_last_nxt  = !len_zero && (run_inc == info.colors_loaded) && (cnt_inc == rd_len);
        out_data_nxt  = {{rle_isd_pkg::OUT_PAD_W{1'b0}}, info.overflow, !len_zero,
                         pix_color[7:0], pix_color[15:8], pix_color[23:16],
                         info.gray, info.height, info.width};
        // zero-length runs are skipped after one invalid pixel
        if (len_zero || (cnt_inc == rd_len)) begin
          cnt_nxt = '0;
          run_nxt = run_inc;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      default: begin
        state_nxt = rle_isd_pkg::EM_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // read cycle only follows an accepted pull
  a_read_after_pull: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rle_isd_pkg::EM_READ) |-> $past(pull_go))
    else $error("expander read without pull");

  // result register is free whenever a read completes
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rle_isd_pkg::EM_READ) |-> !out_valid_r)
    else $error("pixel result would overwrite pending result");

  // expansion never runs past the loaded colors
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    info.emit_phase |-> (run_r <= info.colors_loaded))
    else $error("run index beyond loaded colors");

  // header results carry no pixel flags
  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == rle_isd_pkg::KIND_HEADER))
      |-> (!out_data_r[rle_isd_pkg::PIX_VALID_BIT] && !out_last_r))
    else $error("header result with pixel flags");
`endif

endmodule

FILE: rtl/rle_image_stream_decoder_core.sv
// Top level of the run-length image stream decoder.
//
// Input channel (in_*): each item is either a stream byte (in_tuser = 0,
// byte in in_tdata) or a pull request (in_tuser = 1). Bytes walk the image
// header, the run lengths and the colors; runs are kept in two 1024-entry
// memories (lengths and colors). The fourth byte of the run count gives a
// header result in the cycle after it is accepted. After the last color,
// each pull yields one pixel result via the run memories' registered read
// data and the output register. Unless the output stalls, bytes can be
// taken back to back; a pixel pull drops in_tready during the memory read.
// Pulls before the data is complete or after the last run, and bytes
// after the data, are accepted and give no result.
// Result channel (out_*): one output register. in_tready is high only while
// that register is empty or being taken, so a stalled receiver holds the
// result and backs up the input. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) returns to the start of the header and
// empties the output; the run memories need no clearing.
module rle_image_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] width, [31:16] height, [32] grayscale,
                                  // [40:33] red, [48:41] green, [56:49] blue,
                                  // [57] pixel_valid, [58] overflow, [63:59] zero
  output logic [0:0]  out_tuser,  // [0] kind
  output logic        out_tlast   // last_pixel
);

  rle_isd_pkg::parse_info_t              info;
  rle_isd_pkg::hdr_evt_t                 hdr;
  rle_isd_pkg::store_wr_t                wr;
  logic                                  busy;
  logic                                  in_go;
  logic                                  byte_go;
  logic                                  pull_go;
  logic [rle_isd_pkg::RUN_AW-1:0]        rd_addr;
  logic [rle_isd_pkg::LEN_W-1:0]         rd_len;
  logic [rle_isd_pkg::COLOR_W-1:0]       rd_color;

  // Input handshake
  assign in_tready = !busy && (!out_tvalid || out_tready);
  assign in_go     = in_tvalid && in_tready;
  assign byte_go   = in_go && (in_tuser[0] == rle_isd_pkg::CMD_BYTE);
  assign pull_go   = in_go && (in_tuser[0] == rle_isd_pkg::CMD_PULL);

  rle_isd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_go   (byte_go),
    .data_byte (in_tdata),
    .info      (info),
    .hdr       (hdr),
    .wr        (wr)
  );

  // Run length store
  rle_isd_ram #(
    .WIDTH (rle_isd_pkg::LEN_W),
    .DEPTH (rle_isd_pkg::MAX_RUNS)
  ) u_len_ram (
    .clk   (clk),
    .we    (wr.len_we),
    .waddr (wr.addr),
    .wdata (wr.len_data),
    .raddr (rd_addr),
    .rdata (rd_len)
  );

  // Run color store
  rle_isd_ram #(
    .WIDTH (rle_isd_pkg::COLOR_W),
    .DEPTH (rle_isd_pkg::MAX_RUNS)
  ) u_color_ram (
    .clk   (clk),
    .we    (wr.color_we),
    .waddr (wr.addr),
    .wdata (wr.color_data),
    .raddr (rd_addr),
    .rdata (rd_color)
  );

  rle_isd_expander u_expander (
    .clk        (clk),
    .rst_n      (rst_n),
    .pull_go    (pull_go),
    .busy       (busy),
    .info       (info),
    .hdr        (hdr),
    .rd_addr    (rd_addr),
    .rd_len     (rd_len),
    .rd_color   (rd_color),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser[0]),
    .out_tlast  (out_tlast)
  );

endmodule
